### rtl/sdbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbt_pkg: shared types and constants of the SD SPI block transfer core
// Codes, field widths, sequencer state and result types.
// ----------------------------------------------------------------------------
package sdbt_pkg;

    // Block geometry
    localparam int BLOCK_BYTES = 512;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int BCNT_W      = BLOCK_SHIFT + 1;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int BLOCK_W  = 23;
    localparam int COUNT_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int POLL_W   = 8;
    localparam int BUDGET_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_BUDGET = 1'd1;
    localparam logic [POLL_W-1:0]    POLL_LIMIT_RST  = 8'd20;
    localparam logic [BUDGET_W-1:0]  WAIT_BUDGET_RST = 16'd500;

    // Item action codes
    localparam logic [ACTION_W-1:0] ACT_READ     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EXCHANGE = 2'd2;

    // Final status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_R1      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_COUNT = 2'd3;

    // SD command / token bytes
    localparam logic [BYTE_W-1:0] CMD_START   = 8'h40;
    localparam logic [BYTE_W-1:0] CMD17_READ  = 8'd17;
    localparam logic [BYTE_W-1:0] CMD24_WRITE = 8'd24;
    localparam logic [BYTE_W-1:0] CMD_CRC     = 8'h01;
    localparam logic [BYTE_W-1:0] DATA_TOKEN  = 8'hFE;
    localparam logic [BYTE_W-1:0] IDLE_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;
    localparam logic [4:0]        RESP_MASK   = 5'h1F;
    localparam logic [4:0]        RESP_ACCEPT = 5'h05;
    localparam logic [BCNT_W-1:0] CMD_LAST    = 10'd5;

    typedef enum logic [13:0] {
        PH_IDLE  = 14'b00_0000_0000_0001,
        PH_CMD   = 14'b00_0000_0000_0010,
        PH_DUMMY = 14'b00_0000_0000_0100,
        PH_POLL  = 14'b00_0000_0000_1000,
        PH_TOKEN = 14'b00_0000_0001_0000,
        PH_RDATA = 14'b00_0000_0010_0000,
        PH_RCRC  = 14'b00_0000_0100_0000,
        PH_GAP   = 14'b00_0000_1000_0000,
        PH_TOKTX = 14'b00_0001_0000_0000,
        PH_WDATA = 14'b00_0010_0000_0000,
        PH_WCRC  = 14'b00_0100_0000_0000,
        PH_WRESP = 14'b00_1000_0000_0000,
        PH_BUSY  = 14'b01_0000_0000_0000,
        PH_TAIL  = 14'b10_0000_0000_0000
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic                 is_write;
        logic [BCNT_W-1:0]    byte_counter;
        logic [POLL_W-1:0]    poll_counter;
        logic [BUDGET_W-1:0]  budget_left;
        logic [BLOCK_W-1:0]   current_block;
        logic [COUNT_W-1:0]   blocks_left;
        logic [STATUS_W-1:0]  block_status;
    } seq_state_t;

    localparam seq_state_t STATE_RST = '{
        phase:         PH_IDLE,
        is_write:      1'b0,
        byte_counter:  '0,
        poll_counter:  '0,
        budget_left:   '0,
        current_block: '0,
        blocks_left:   '0,
        block_status:  ST_OK
    };

    typedef struct packed {
        logic [BYTE_W-1:0]   mosi_byte;
        logic                mosi_valid;
        logic                card_selected;
        logic [BYTE_W-1:0]   read_byte;
        logic                read_valid;
        logic                payload_taken;
        logic                done_res;
        logic [STATUS_W-1:0] status;
    } seq_result_t;

    // Byte i of the six-byte command frame; byte address = block * BLOCK_BYTES
    function automatic logic [BYTE_W-1:0] cmd_byte(
        input logic [2:0]         idx,
        input logic               wr,
        input logic [BLOCK_W-1:0] blk
    );
        logic [31:0] addr;
        logic [BYTE_W-1:0] b;
        addr = 32'({blk, {BLOCK_SHIFT{1'b0}}});
        case (idx)
            3'd0:    b = CMD_START | (wr ? CMD24_WRITE : CMD17_READ);
            3'd1:    b = addr[31:24];
            3'd2:    b = addr[23:16];
            3'd3:    b = addr[15:8];
            3'd4:    b = addr[7:0];
            default: b = CMD_CRC;
        endcase
        return b;
    endfunction

endpackage

### rtl/sdbt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbt_if: item channels of the SD SPI block transfer core
// Request channel (start / exchange items) and result channel.
// ----------------------------------------------------------------------------
interface sdbt_req_if
    import sdbt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BLOCK_W-1:0]  block_address;
    logic [COUNT_W-1:0]  block_count;
    logic [BYTE_W-1:0]   miso_byte;
    logic [BYTE_W-1:0]   payload_byte;

    modport source (output valid, action, block_address, block_count, miso_byte,
                    payload_byte, input ready);
    modport sink   (input valid, action, block_address, block_count, miso_byte,
                    payload_byte, output ready);
endinterface

interface sdbt_res_if
    import sdbt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   mosi_byte;
    logic                mosi_valid;
    logic                card_selected;
    logic [BYTE_W-1:0]   read_byte;
    logic                read_valid;
    logic                payload_taken;
    logic                done_res;
    logic [STATUS_W-1:0] status;

    modport source (output valid, mosi_byte, mosi_valid, card_selected, read_byte,
                    read_valid, payload_taken, done_res, status, input ready);
    modport sink   (input valid, mosi_byte, mosi_valid, card_selected, read_byte,
                    read_valid, payload_taken, done_res, status, output ready);
endinterface

### rtl/sdbt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdbt_step: next-state and result logic of the transfer sequencer
// Purely combinational; one item in, new state and one result out.
// ----------------------------------------------------------------------------
module sdbt_step
    import sdbt_pkg::*;
(
    input  seq_state_t          cur,
    input  logic [ACTION_W-1:0] action,
    input  logic [BLOCK_W-1:0]  block_address,
    input  logic [COUNT_W-1:0]  block_count,
    input  logic [BYTE_W-1:0]   miso_byte,
    input  logic [BYTE_W-1:0]   payload_byte,
    input  logic [POLL_W-1:0]   poll_limit,
    input  logic [BUDGET_W-1:0] wait_budget,
    output seq_state_t          nxt,
    output seq_result_t         res
);

    logic [BUDGET_W-1:0] budget_dec;
    logic [COUNT_W-1:0]  blocks_dec;
    logic [BLOCK_W-1:0]  block_inc;
    logic [BCNT_W-1:0]   cnt_inc;

    assign budget_dec = cur.budget_left - 1'b1;
    assign blocks_dec = cur.blocks_left - 1'b1;
    assign block_inc  = cur.current_block + 1'b1;
    assign cnt_inc    = cur.byte_counter + 1'b1;

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.card_selected = (cur.phase != PH_IDLE) && (cur.phase != PH_TAIL);

        if (action inside {ACT_READ, ACT_WRITE})
        begin
            if (cur.phase == PH_IDLE)
            begin
                if (block_count == '0)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_ZERO_COUNT;
                end
                else
                begin
                    nxt.is_write      = action[0];
                    nxt.current_block = block_address;
                    nxt.blocks_left   = block_count;
                    nxt.block_status  = ST_OK;
                    nxt.poll_counter  = '0;
                    nxt.budget_left   = '0;
                    nxt.phase         = PH_CMD;
                    nxt.byte_counter  = '0;
                    res.mosi_byte     = cmd_byte(3'd0, action[0], block_address);
                    res.mosi_valid    = 1'b1;
                    res.card_selected = 1'b1;
                end
            end
        end
        else if (action == ACT_EXCHANGE)
        begin
            // default: selected, byte will be set per phase
            case (cur.phase)
                PH_IDLE:
                begin
                end
                PH_CMD:
                begin
                    res.mosi_valid    = 1'b1;
                    res.card_selected = 1'b1;
                    if (cur.byte_counter < CMD_LAST)
                    begin
                        nxt.byte_counter = cnt_inc;
                        res.mosi_byte    = cmd_byte(cnt_inc[2:0], cur.is_write,
                                                    cur.current_block);
                    end
                    else
                    begin
                        nxt.phase     = PH_DUMMY;
                        res.mosi_byte = IDLE_BYTE;
                    end
                end
                PH_DUMMY:
                begin
                    res.mosi_valid = 1'b1;
                    res.mosi_byte  = IDLE_BYTE;
                    if (poll_limit == '0)
                    begin
                        nxt.block_status = ST_NO_R1;
                        nxt.phase        = PH_TAIL;
                        nxt.byte_counter = '0;
                        res.card_selected = 1'b0;
                    end
                    else
                    begin
                        nxt.poll_counter  = POLL_W'(1);
                        nxt.phase         = PH_POLL;
                        res.card_selected = 1'b1;
                    end
                end
                PH_POLL:
                begin
                    res.mosi_valid    = 1'b1;
                    res.mosi_byte     = IDLE_BYTE;
                    res.card_selected = 1'b1;
                    if (miso_byte == ZERO_BYTE)
                    begin
                        if (cur.is_write)
                        begin
                            nxt.phase        = PH_GAP;
                            nxt.byte_counter = '0;
                        end
                        else if (wait_budget == '0)
                        begin
                            nxt.block_status  = ST_TIMEOUT;
                            nxt.phase         = PH_TAIL;
                            nxt.byte_counter  = '0;
                            res.card_selected = 1'b0;
                        end
                        else
                        begin
                            nxt.budget_left = wait_budget;
                            nxt.phase       = PH_TOKEN;
                            res.mosi_byte   = ZERO_BYTE;
                        end
                    end
                    else if (cur.poll_counter < poll_limit)
                    begin
                        nxt.poll_counter = cur.poll_counter + 1'b1;
                    end
                    else
                    begin
                        nxt.block_status  = ST_NO_R1;
                        nxt.phase         = PH_TAIL;
                        nxt.byte_counter  = '0;
                        res.card_selected = 1'b0;
                    end
                end
                PH_TOKEN:
                begin
                    res.mosi_valid    = 1'b1;
                    res.mosi_byte     = ZERO_BYTE;
                    res.card_selected = 1'b1;
                    if (miso_byte == DATA_TOKEN)
                    begin
                        nxt.phase        = PH_RDATA;
                        nxt.byte_counter = '0;
                    end
                    else
                    begin
                        nxt.budget_left = budget_dec;
                        if (budget_dec == '0)
                        begin
                            nxt.block_status  = ST_TIMEOUT;
                            nxt.phase         = PH_TAIL;
                            nxt.byte_counter  = '0;
                            res.mosi_byte     = IDLE_BYTE;
                            res.card_selected = 1'b0;
                        end
                    end
                end
                PH_RDATA:
                begin
                    res.read_byte     = miso_byte;
                    res.read_valid    = 1'b1;
                    res.mosi_valid    = 1'b1;
                    res.mosi_byte     = ZERO_BYTE;
                    res.card_selected = 1'b1;
                    if (cur.byte_counter != BCNT_W'(BLOCK_BYTES - 1))
                        nxt.byte_counter = cnt_inc;
                    else
                    begin
                        nxt.phase        = PH_RCRC;
                        nxt.byte_counter = '0;
                    end
                end
                PH_RCRC:
                begin
                    res.mosi_valid = 1'b1;
                    if (cur.byte_counter == '0)
                    begin
                        nxt.byte_counter  = BCNT_W'(1);
                        res.mosi_byte     = ZERO_BYTE;
                        res.card_selected = 1'b1;
                    end
                    else
                    begin
                        nxt.block_status  = ST_OK;
                        nxt.phase         = PH_TAIL;
                        nxt.byte_counter  = '0;
                        res.mosi_byte     = IDLE_BYTE;
                        res.card_selected = 1'b0;
                    end
                end
                PH_GAP:
                begin
                    res.mosi_valid    = 1'b1;
                    res.card_selected = 1'b1;
                    if (cur.byte_counter == '0)
                    begin
                        nxt.byte_counter = BCNT_W'(1);
                        res.mosi_byte    = IDLE_BYTE;
                    end
                    else
                    begin
                        nxt.phase     = PH_TOKTX;
                        res.mosi_byte = DATA_TOKEN;
                    end
                end
                PH_TOKTX:
                begin
                    nxt.phase          = PH_WDATA;
                    nxt.byte_counter   = '0;
                    res.payload_taken  = 1'b1;
                    res.mosi_valid     = 1'b1;
                    res.mosi_byte      = payload_byte;
                    res.card_selected  = 1'b1;
                end
                PH_WDATA:
                begin
                    res.mosi_valid    = 1'b1;
                    res.card_selected = 1'b1;
                    if (cur.byte_counter != BCNT_W'(BLOCK_BYTES - 1))
                    begin
                        nxt.byte_counter  = cnt_inc;
                        res.payload_taken = 1'b1;
                        res.mosi_byte     = payload_byte;
                    end
                    else
                    begin
                        nxt.phase        = PH_WCRC;
                        nxt.byte_counter = '0;
                        res.mosi_byte    = IDLE_BYTE;
                    end
                end
                PH_WCRC:
                begin
                    res.mosi_valid = 1'b1;
                    res.mosi_byte  = IDLE_BYTE;
                    if (cur.byte_counter == '0)
                    begin
                        nxt.byte_counter  = BCNT_W'(1);
                        res.card_selected = 1'b1;
                    end
                    else if (wait_budget == '0)
                    begin
                        nxt.block_status  = ST_TIMEOUT;
                        nxt.phase         = PH_TAIL;
                        nxt.byte_counter  = '0;
                        res.card_selected = 1'b0;
                    end
                    else
                    begin
                        nxt.budget_left   = wait_budget;
                        nxt.phase         = PH_WRESP;
                        res.card_selected = 1'b1;
                    end
                end
                PH_WRESP, PH_BUSY:
                begin
                    res.mosi_valid    = 1'b1;
                    res.mosi_byte     = IDLE_BYTE;
                    res.card_selected = 1'b1;
                    if ((cur.phase == PH_WRESP) && ((miso_byte[4:0] & RESP_MASK) == RESP_ACCEPT))
                        nxt.phase = PH_BUSY;
                    else if ((cur.phase == PH_BUSY) && (miso_byte == IDLE_BYTE))
                    begin
                        nxt.block_status  = ST_OK;
                        nxt.phase         = PH_TAIL;
                        nxt.byte_counter  = '0;
                        res.card_selected = 1'b0;
                    end
                    else
                    begin
                        nxt.budget_left = budget_dec;
                        if (budget_dec == '0)
                        begin
                            nxt.block_status  = ST_TIMEOUT;
                            nxt.phase         = PH_TAIL;
                            nxt.byte_counter  = '0;
                            res.card_selected = 1'b0;
                        end
                    end
                end
                PH_TAIL:
                begin
                    res.card_selected = 1'b0;
                    if (cur.byte_counter == '0)
                    begin
                        nxt.byte_counter = BCNT_W'(1);
                        res.mosi_valid   = 1'b1;
                        res.mosi_byte    = IDLE_BYTE;
                    end
                    else
                    begin
                        nxt.blocks_left = blocks_dec;
                        if (blocks_dec == '0)
                        begin
                            nxt.phase    = PH_IDLE;
                            res.done_res = 1'b1;
                            res.status   = cur.block_status;
                        end
                        else
                        begin
                            nxt.current_block = block_inc;
                            nxt.phase         = PH_CMD;
                            nxt.byte_counter  = '0;
                            res.mosi_valid    = 1'b1;
                            res.mosi_byte     = cmd_byte(3'd0, cur.is_write, block_inc);
                            res.card_selected = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

### rtl/sd_spi_block_transfer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_block_transfer_core: SD card SPI-mode block read/write sequencer
// Turns start items and completed SPI byte exchanges into the next byte to
// send, chip select, read data and the final transfer status.
// ----------------------------------------------------------------------------
// Usage:
//   request: a start item (action read or write, block_address, block_count)
//     opens a transfer; each later exchange item reports the byte received in
//     the SPI exchange just finished (miso_byte) plus the next payload byte.
//   result: exactly one item per request item: next mosi byte and whether to
//     run another exchange, chip select, a read data byte, payload_taken
//     (payload_byte was consumed), and done_res/status at the end.
//   cfg: plain write port; index 0 = R1 poll limit, 1 = token/busy wait budget.
//     Write only while no transfer is running.
// Output: a result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle while the receiver keeps up; the step logic sits
//   between the state register and the result register, so nothing iterates.
// Stall: the result register holds while the receiver stalls; a new item is
//   still accepted in the same cycle the held result is taken.
// Reset: sequencer idle, no result valid, poll limit 20, wait budget 500.
// ----------------------------------------------------------------------------
module sd_spi_block_transfer_core
    import sdbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sdbt_req_if.sink              request,
    sdbt_res_if.source            result
);

    seq_state_t          state_reg;
    seq_state_t          state_next;
    seq_result_t         res_reg;
    seq_result_t         res_next;
    logic                res_valid_reg;
    logic [POLL_W-1:0]   poll_limit_reg;
    logic [BUDGET_W-1:0] wait_budget_reg;
    logic                accept;

    // Output register frees up when empty or being drained this cycle
    assign request.ready = !res_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg  <= POLL_LIMIT_RST;
            wait_budget_reg <= WAIT_BUDGET_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_POLL_LIMIT:  poll_limit_reg  <= cfg_data[POLL_W-1:0];
                CFG_WAIT_BUDGET: wait_budget_reg <= cfg_data[BUDGET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sdbt_step u_step (
        .cur           (state_reg),
        .action        (request.action),
        .block_address (request.block_address),
        .block_count   (request.block_count),
        .miso_byte     (request.miso_byte),
        .payload_byte  (request.payload_byte),
        .poll_limit    (poll_limit_reg),
        .wait_budget   (wait_budget_reg),
        .nxt           (state_next),
        .res           (res_next)
    );

    // Sequencer state advances once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign result.valid         = res_valid_reg;
    assign result.mosi_byte     = res_reg.mosi_byte;
    assign result.mosi_valid    = res_reg.mosi_valid;
    assign result.card_selected = res_reg.card_selected;
    assign result.read_byte     = res_reg.read_byte;
    assign result.read_valid    = res_reg.read_valid;
    assign result.payload_taken = res_reg.payload_taken;
    assign result.done_res      = res_reg.done_res;
    assign result.status        = res_reg.status;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sd_spi_block_transfer_core
// Plays the host side of a card conversation: start items open read or write
// transfers, exchange items return card bytes shaped by a per-transfer card
// temperament (ready, mute, stalled, noisy). Every accepted item is run
// through an in-bench sequencer model whose expected result is compared field
// by field with the block's output. Both channels idle and stall at random,
// and the run walks through several poll-limit / wait-budget settings,
// including zero and full-scale values.
// ----------------------------------------------------------------------------
module tb;
    import sdbt_pkg::*;

    localparam int HALF_PERIOD_NS = 6;
    localparam int RESET_CYCLES   = 12;
    // Longest quiet stretch in a correct run is the forced receiver hold
    // plus a long sender gap plus a config pause; this limit is
    // that stretch taken many times over.
    localparam int QUIET_LIMIT    = 4000;
    localparam int FORCED_HOLD    = 150;
    localparam int HOLD_AFTER     = 400;

    // Action code the block does not define; must be ignored
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BLOCK_W-1:0]  block_address;
        logic [COUNT_W-1:0]  block_count;
        logic [BYTE_W-1:0]   miso_byte;
        logic [BYTE_W-1:0]   payload_byte;
    } xfer_req_t;

    // How the emulated card answers during one transfer
    typedef enum int {
        CARD_READY,
        CARD_MUTE,
        CARD_STALLED,
        CARD_NOISY
    } card_mood_t;

    // ------------------------------------------------------------------------
    // Sequencer model plus queue of the results it predicts
    // ------------------------------------------------------------------------
    class xfer_tracker;
        phase_t              ph;
        logic                wr;
        logic [BCNT_W-1:0]   bcnt;
        logic [POLL_W-1:0]   polls;
        logic [BUDGET_W-1:0] budget;
        logic [BLOCK_W-1:0]  blk;
        logic [COUNT_W-1:0]  left;
        logic [STATUS_W-1:0] blk_status;
        logic [POLL_W-1:0]   poll_limit;
        logic [BUDGET_W-1:0] wait_limit;
        seq_result_t         nxt;
        seq_result_t         pending_results[$];
        int                  mismatches;
        int                  checked;

        function new();
            ph = PH_IDLE;
            wr = 1'b0;
            bcnt = '0;
            polls = '0;
            budget = '0;
            blk = '0;
            left = '0;
            blk_status = ST_OK;
            poll_limit = POLL_LIMIT_RST;
            wait_limit = WAIT_BUDGET_RST;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_POLL_LIMIT)
                poll_limit = val[POLL_W-1:0];
            else if (idx == CFG_WAIT_BUDGET)
                wait_limit = val[BUDGET_W-1:0];
        endfunction

        // Six-byte command frame: opcode, 32-bit byte address, fixed CRC
        function logic [BYTE_W-1:0] frame_byte(input int i);
            logic [31:0] byte_addr;
            byte_addr = {blk, {BLOCK_SHIFT{1'b0}}};
            case (i)
                0:       return CMD_START | (wr ? CMD24_WRITE : CMD17_READ);
                1:       return byte_addr[31:24];
                2:       return byte_addr[23:16];
                3:       return byte_addr[15:8];
                4:       return byte_addr[7:0];
                default: return CMD_CRC;
            endcase
        endfunction

        function void send(input logic [BYTE_W-1:0] b, input logic cs);
            nxt.mosi_byte = b;
            nxt.mosi_valid = 1'b1;
            nxt.card_selected = cs;
        endfunction

        function void open_block();
            ph = PH_CMD;
            bcnt = '0;
            send(frame_byte(0), 1'b1);
        endfunction

        function void close_block(input logic [STATUS_W-1:0] st);
            blk_status = st;
            ph = PH_TAIL;
            bcnt = '0;
            send(IDLE_BYTE, 1'b0);
        endfunction

        // First poll of a budgeted wait goes out with the phase change
        function void begin_wait(input phase_t p, input logic [BYTE_W-1:0] poll);
            if (wait_limit == 0)
                close_block(ST_TIMEOUT);
            else
            begin
                budget = wait_limit;
                ph = p;
                send(poll, 1'b1);
            end
        endfunction

        function void burn_budget(input logic [BYTE_W-1:0] poll);
            budget = budget - 1'b1;
            if (budget != 0)
                send(poll, 1'b1);
            else
                close_block(ST_TIMEOUT);
        endfunction

        function void advance(input logic [BYTE_W-1:0] miso, input logic [BYTE_W-1:0] pay);
            case (ph)
                PH_CMD:
                begin
                    if (bcnt < CMD_LAST)
                    begin
                        bcnt = bcnt + 1'b1;
                        send(frame_byte(int'(bcnt)), 1'b1);
                    end
                    else
                    begin
                        ph = PH_DUMMY;
                        send(IDLE_BYTE, 1'b1);
                    end
                end
                PH_DUMMY:
                begin
                    if (poll_limit == 0)
                        close_block(ST_NO_R1);
                    else
                    begin
                        polls = POLL_W'(1);
                        ph = PH_POLL;
                        send(IDLE_BYTE, 1'b1);
                    end
                end
                PH_POLL:
                begin
                    if (miso == ZERO_BYTE)
                    begin
                        if (wr)
                        begin
                            ph = PH_GAP;
                            bcnt = '0;
                            send(IDLE_BYTE, 1'b1);
                        end
                        else
                            begin_wait(PH_TOKEN, ZERO_BYTE);
                    end
                    else if (polls < poll_limit)
                    begin
                        polls = polls + 1'b1;
                        send(IDLE_BYTE, 1'b1);
                    end
                    else
                        close_block(ST_NO_R1);
                end
                PH_TOKEN:
                begin
                    if (miso == DATA_TOKEN)
                    begin
                        ph = PH_RDATA;
                        bcnt = '0;
                        send(ZERO_BYTE, 1'b1);
                    end
                    else
                        burn_budget(ZERO_BYTE);
                end
                PH_RDATA:
                begin
                    nxt.read_byte = miso;
                    nxt.read_valid = 1'b1;
                    if (int'(bcnt) < BLOCK_BYTES - 1)
                        bcnt = bcnt + 1'b1;
                    else
                    begin
                        ph = PH_RCRC;
                        bcnt = '0;
                    end
                    send(ZERO_BYTE, 1'b1);
                end
                PH_RCRC:
                begin
                    if (bcnt == 0)
                    begin
                        bcnt = BCNT_W'(1);
                        send(ZERO_BYTE, 1'b1);
                    end
                    else
                        close_block(ST_OK);
                end
                PH_GAP:
                begin
                    if (bcnt == 0)
                    begin
                        bcnt = BCNT_W'(1);
                        send(IDLE_BYTE, 1'b1);
                    end
                    else
                    begin
                        ph = PH_TOKTX;
                        send(DATA_TOKEN, 1'b1);
                    end
                end
                PH_TOKTX:
                begin
                    ph = PH_WDATA;
                    bcnt = '0;
                    nxt.payload_taken = 1'b1;
                    send(pay, 1'b1);
                end
                PH_WDATA:
                begin
                    if (int'(bcnt) < BLOCK_BYTES - 1)
                    begin
                        bcnt = bcnt + 1'b1;
                        nxt.payload_taken = 1'b1;
                        send(pay, 1'b1);
                    end
                    else
                    begin
                        ph = PH_WCRC;
                        bcnt = '0;
                        send(IDLE_BYTE, 1'b1);
                    end
                end
                PH_WCRC:
                begin
                    if (bcnt == 0)
                    begin
                        bcnt = BCNT_W'(1);
                        send(IDLE_BYTE, 1'b1);
                    end
                    else
                        begin_wait(PH_WRESP, IDLE_BYTE);
                end
                PH_WRESP:
                begin
                    if ((miso[4:0] & RESP_MASK) == RESP_ACCEPT)
                    begin
                        ph = PH_BUSY;
                        send(IDLE_BYTE, 1'b1);
                    end
                    else
                        burn_budget(IDLE_BYTE);
                end
                PH_BUSY:
                begin
                    if (miso == IDLE_BYTE)
                        close_block(ST_OK);
                    else
                        burn_budget(IDLE_BYTE);
                end
                PH_TAIL:
                begin
                    if (bcnt == 0)
                    begin
                        bcnt = BCNT_W'(1);
                        send(IDLE_BYTE, 1'b0);
                    end
                    else
                    begin
                        left = left - 1'b1;
                        if (left == 0)
                        begin
                            ph = PH_IDLE;
                            nxt.done_res = 1'b1;
                            nxt.status = blk_status;
                            nxt.card_selected = 1'b0;
                        end
                        else
                        begin
                            blk = blk + 1'b1;
                            open_block();
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // One accepted item -> exactly one expected result
        function void take_request(input xfer_req_t r);
            nxt = '0;
            nxt.card_selected = (ph != PH_IDLE && ph != PH_TAIL);
            if (r.action == ACT_READ || r.action == ACT_WRITE)
            begin
                if (ph == PH_IDLE)
                begin
                    if (r.block_count == 0)
                    begin
                        nxt.done_res = 1'b1;
                        nxt.status = ST_ZERO_COUNT;
                    end
                    else
                    begin
                        wr = (r.action == ACT_WRITE);
                        blk = r.block_address;
                        left = r.block_count;
                        blk_status = ST_OK;
                        polls = '0;
                        budget = '0;
                        open_block();
                    end
                end
            end
            else if (r.action == ACT_EXCHANGE && ph != PH_IDLE)
                advance(r.miso_byte, r.payload_byte);
            pending_results.push_back(nxt);
        endfunction

        task report(input string what, input logic [31:0] got_v, input logic [31:0] want_v);
            mismatches++;
            $display("result %0d: %s got 0x%0h, want 0x%0h", checked, what, got_v, want_v);
        endtask

        task match_result(input seq_result_t got);
            seq_result_t want;
            checked++;
            if (pending_results.size() == 0)
            begin
                report("result with no item pending", 0, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.mosi_byte !== want.mosi_byte)
                report("mosi_byte", 32'(got.mosi_byte), 32'(want.mosi_byte));
            if (got.mosi_valid !== want.mosi_valid)
                report("mosi_valid", 32'(got.mosi_valid), 32'(want.mosi_valid));
            if (got.card_selected !== want.card_selected)
                report("card_selected", 32'(got.card_selected), 32'(want.card_selected));
            if (got.read_byte !== want.read_byte)
                report("read_byte", 32'(got.read_byte), 32'(want.read_byte));
            if (got.read_valid !== want.read_valid)
                report("read_valid", 32'(got.read_valid), 32'(want.read_valid));
            if (got.payload_taken !== want.payload_taken)
                report("payload_taken", 32'(got.payload_taken), 32'(want.payload_taken));
            if (got.done_res !== want.done_res)
                report("done_res", 32'(got.done_res), 32'(want.done_res));
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    always #HALF_PERIOD_NS clk = ~clk;

    sdbt_req_if req_ch ();
    sdbt_res_if res_ch ();

    sd_spi_block_transfer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .request      (req_ch),
        .result       (res_ch)
    );

    xfer_tracker tracker;
    card_mood_t  mood = CARD_READY;
    int          calm_items = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. The result side is
    // checked first; a result can never belong to the item accepted on the
    // same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : sample
        xfer_req_t   req;
        seq_result_t res;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                res.mosi_byte = res_ch.mosi_byte;
                res.mosi_valid = res_ch.mosi_valid;
                res.card_selected = res_ch.card_selected;
                res.read_byte = res_ch.read_byte;
                res.read_valid = res_ch.read_valid;
                res.payload_taken = res_ch.payload_taken;
                res.done_res = res_ch.done_res;
                res.status = res_ch.status;
                tracker.match_result(res);
                results_seen++;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                req.action = req_ch.action;
                req.block_address = req_ch.block_address;
                req.block_count = req_ch.block_count;
                req.miso_byte = req_ch.miso_byte;
                req.payload_byte = req_ch.payload_byte;
                tracker.take_request(req);
            end
            if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Watchdog: read at the falling edge, away from the monitor's updates
    initial
    begin
        while (idle_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, mostly short; a few long; calm stretches with
    // ready held high. One forced long hold once traffic is flowing, so the
    // result register backs up and the block drops request ready.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;
        int calm;
        int r;
        bit forced;
        hold = 0;
        calm = 0;
        forced = 1'b0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!forced && results_seen >= HOLD_AFTER)
            begin
                forced = 1'b1;
                hold = FORCED_HOLD;
            end
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (calm > 0)
                    calm--;
                else
                begin
                    r = $urandom_range(99);
                    if (r >= 70 && r < 95)
                        hold = $urandom_range(3, 1);
                    else if (r >= 95 && r < 98)
                        hold = $urandom_range(60, 15);
                    else if (r >= 98)
                        calm = $urandom_range(300, 50);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers. Inputs change only at the falling edge; every task
    // returns at a falling edge.
    // ------------------------------------------------------------------------

    // Offer one item and hold it until the block takes it
    task automatic offer(input xfer_req_t it);
        req_ch.valid <= 1'b1;
        req_ch.action <= it.action;
        req_ch.block_address <= it.block_address;
        req_ch.block_count <= it.block_count;
        req_ch.miso_byte <= it.miso_byte;
        req_ch.payload_byte <= it.payload_byte;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Idle the request side for a while, or not at all
    task automatic sender_gap();
        int r;
        int len;
        if (calm_items > 0)
        begin
            calm_items--;
            return;
        end
        r = $urandom_range(99);
        if (r < 55)
            return;
        if (r >= 97)
        begin
            calm_items = $urandom_range(300, 50);
            return;
        end
        len = (r < 92) ? $urandom_range(3, 1) : $urandom_range(40, 10);
        req_ch.valid <= 1'b0;
        repeat (len) @(negedge clk);
    endtask

    // Stop offering until every predicted result has been taken
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.pending_results.size() != 0);
    endtask

    function automatic xfer_req_t random_item(input logic [ACTION_W-1:0] act);
        xfer_req_t it;
        it.action = act;
        it.block_address = BLOCK_W'($urandom);
        it.block_count = COUNT_W'($urandom);
        it.miso_byte = BYTE_W'($urandom);
        it.payload_byte = BYTE_W'($urandom);
        return it;
    endfunction

    // Byte the card returns, given where the sequencer stands right now
    function automatic logic [BYTE_W-1:0] card_reply();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        if (mood == CARD_NOISY)
            return b;
        case (tracker.ph)
            PH_POLL:
            begin
                if (mood != CARD_MUTE && $urandom_range(2) == 0)
                    b = ZERO_BYTE;
                else if (b == ZERO_BYTE || $urandom_range(1) == 0)
                    b = IDLE_BYTE;
            end
            PH_TOKEN:
            begin
                if (mood == CARD_READY && $urandom_range(3) == 0)
                    b = DATA_TOKEN;
                else if (b == DATA_TOKEN)
                    b = IDLE_BYTE;
            end
            PH_WRESP:
            begin
                // accepted response: top bits random, low five fixed
                if (mood == CARD_READY && $urandom_range(2) == 0)
                    b[4:0] = RESP_ACCEPT;
                else if (b[4:0] == RESP_ACCEPT)
                    b[0] = ~b[0];
            end
            PH_BUSY:
            begin
                if (mood == CARD_READY && $urandom_range(3) == 0)
                    b = IDLE_BYTE;
                else if (b == IDLE_BYTE)
                    b = ZERO_BYTE;
            end
            default: ;
        endcase
        return b;
    endfunction

    // A stalled card never ends a wait, so keep it off large budgets
    function automatic card_mood_t pick_mood();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return CARD_READY;
        if (r < 75)
            return CARD_MUTE;
        if (r < 85 && tracker.wait_limit <= 4000)
            return CARD_STALLED;
        return CARD_NOISY;
    endfunction

    // Mostly single blocks: a good block costs over 500 exchanges
    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return COUNT_W'(1);
        if (r < 95)
            return COUNT_W'($urandom_range(3, 2));
        return COUNT_W'($urandom_range(6, 4));
    endfunction

    // Exchange items with card answers until the transfer is over
    task automatic finish_transfer();
        xfer_req_t it;
        while (tracker.ph != PH_IDLE)
        begin
            it = random_item(ACT_EXCHANGE);
            it.miso_byte = card_reply();
            offer(it);
            sender_gap();
        end
    endtask

    task automatic set_config(input logic [POLL_W-1:0] lim, input logic [BUDGET_W-1:0] bud);
        drain_results();
        repeat (2) @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= CFG_POLL_LIMIT;
        cfg_data <= CFG_DATA_W'(lim);
        @(negedge clk);
        cfg_index <= CFG_WAIT_BUDGET;
        cfg_data <= bud;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        tracker.set_reg(CFG_POLL_LIMIT, CFG_DATA_W'(lim));
        tracker.set_reg(CFG_WAIT_BUDGET, bud);
    endtask

    // Zero counts, ignored actions, and a two-block read from the top block
    // number that wraps to block zero, with a mute card so both blocks fail
    // on the R1 poll limit.
    task automatic edge_case_items();
        xfer_req_t it;
        it = random_item(ACT_READ);
        it.block_address = '1;
        it.block_count = '0;
        offer(it);
        it = random_item(ACT_WRITE);
        it.block_address = '0;
        it.block_count = '0;
        offer(it);
        it = random_item(ACT_EXCHANGE);
        it.miso_byte = '1;
        it.payload_byte = '1;
        offer(it);
        it = random_item(ACT_UNUSED);
        it.block_address = '0;
        offer(it);
        mood = CARD_MUTE;
        it = random_item(ACT_READ);
        it.block_address = '1;
        it.block_count = COUNT_W'(2);
        offer(it);
        it = random_item(ACT_EXCHANGE);
        it.miso_byte = '0;
        it.payload_byte = '0;
        offer(it);
        // start while busy: must be ignored
        it = random_item(ACT_WRITE);
        it.block_address = '1;
        it.block_count = '1;
        offer(it);
        it.action = ACT_UNUSED;
        offer(it);
        finish_transfer();
    endtask

    // Random traffic; n counts only items the block acts on
    task automatic random_run(input int n);
        xfer_req_t it;
        int        live;
        int        r;
        bit        busy;
        live = 0;
        while (live < n)
        begin
            busy = (tracker.ph != PH_IDLE);
            if (busy && $urandom_range(299) == 0)
                drain_results();
            r = $urandom_range(999);
            if (!busy)
            begin
                if (r < 850)
                begin
                    mood = pick_mood();
                    it = random_item($urandom_range(1) ? ACT_WRITE : ACT_READ);
                    if ($urandom_range(9) == 0)
                        it.block_address = '1 - BLOCK_W'($urandom_range(1));
                    it.block_count = pick_count();
                end
                else if (r < 900)
                begin
                    it = random_item($urandom_range(1) ? ACT_WRITE : ACT_READ);
                    it.block_count = '0;
                end
                else if (r < 950)
                    it = random_item(ACT_EXCHANGE);
                else
                    it = random_item(ACT_UNUSED);
                if (it.action == ACT_READ || it.action == ACT_WRITE)
                    live++;
            end
            else
            begin
                if (r < 970)
                begin
                    it = random_item(ACT_EXCHANGE);
                    it.miso_byte = card_reply();
                    live++;
                end
                else if (r < 985)
                    it = random_item($urandom_range(1) ? ACT_WRITE : ACT_READ);
                else
                    it = random_item(ACT_UNUSED);
            end
            offer(it);
            sender_gap();
        end
        finish_transfer();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence. A transfer that is under way when a run reaches its
    // count is always finished, and a good block alone is over 500 items, so
    // the run counts are kept small.
    // ------------------------------------------------------------------------
    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = CFG_POLL_LIMIT;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_READ;
        req_ch.block_address = '0;
        req_ch.block_count = '0;
        req_ch.miso_byte = '0;
        req_ch.payload_byte = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: poll limit 20, budget 500
        edge_case_items();
        random_run(200);

        // zero poll limit: every block fails without polling
        set_config(8'd0, 16'd1);
        random_run(150);

        // zero budget: reads that pass R1 fail at once, writes after their data block
        set_config(8'd1, 16'd0);
        random_run(80);

        // full-scale limits
        set_config(8'hFF, 16'hFFFF);
        random_run(80);

        drain_results();
        repeat (4) @(negedge clk);
        if (tracker.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
